// ===== sv/wisct_pkg.sv =====
// Shared constants and codes for the wrapped-index set-or-count table.
`default_nettype none

package wisct_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int RESET_LENGTH  = 12;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 32;
    localparam int CMD_W         = 2;
    localparam int INDEX_W       = 6;
    localparam int LEN_CFG_W     = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_DUMP  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIST_LENGTH = 1'b0,
        REG_SET_VALUE   = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== sv/wisct_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module wisct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/wisct_div.sv =====
// Bit-serial true-modulo unit: wraps a signed position into 0..divisor-1.
`default_nettype none

module wisct_div #(
    parameter int LEN_W = 7,
    parameter int OUT_W = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [wisct_pkg::POS_W-1:0] dividend,
    input  wire logic        [LEN_W-1:0]       divisor,
    output logic                               done,
    output logic             [OUT_W-1:0]       result
);

    import wisct_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] dvd_reg, dvd_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [OUT_W-1:0] res_reg, res_next;

    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic [LEN_W-1:0] rem_step;
    logic [LEN_W-1:0] rem_fixed;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[POS_W-1]};
        diff      = trial - {1'b0, den_reg};
        rem_step  = (trial >= {1'b0, den_reg}) ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        rem_fixed = (neg_reg && (rem_step != '0)) ? LEN_W'(den_reg - rem_step) : rem_step;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend[POS_W-1] ? POS_W'(-dividend) : POS_W'(dividend);
            rem_next  = '0;
            den_next  = divisor;
            neg_next  = dividend[POS_W-1];
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
            rem_next = rem_step;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(POS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = OUT_W'(rem_fixed);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== sv/wrapped_index_set_or_count_table_top.sv =====
// Wrapped-index set-or-count table: sequencer, entry storage and output register.
//
// Input channel (in_valid/in_ready) takes one command transaction at a time:
//   mark  - wrap position into 0..list_length-1 (true modulo), then overwrite
//           the entry with set_value, or increment it when set_value is zero.
//   clear - zero every entry.
//   dump  - emit entries 0..list_length-1 on the output channel, last_entry
//           set on the final one.
// Config channel (cfg_valid/cfg_ready) is always ready; write only while idle.
// Index 0 is list_length (clamped to 1..DEPTH), index 1 is set_value.
// Sequencing: a mark holds in_ready low through the bit-serial modulo unit (32
// steps plus its result register), then one RAM read and one write, so no new
// command is accepted until the mark completes; a clear or an unused command
// leaves in_ready high; each dumped entry passes through a RAM read, a wait for
// the read data and the output register.
// A receiver stall holds the output register and the dump counter.
// Reset clears all per-entry valid flags, so every entry reads as zero, and
// loads list_length 12 (or DEPTH if smaller) and set_value 0.
`default_nettype none

module wrapped_index_set_or_count_table_top #(
    parameter int DEPTH = wisct_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic        [wisct_pkg::CMD_W-1:0]      command,
    input  wire logic signed [wisct_pkg::POS_W-1:0]      position,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed      [wisct_pkg::DATA_W-1:0]     entry_value,
    output logic             [wisct_pkg::INDEX_W-1:0]    entry_index,
    output logic                                      last_entry,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [wisct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [wisct_pkg::CFG_DATA_W-1:0] cfg_data
);

    import wisct_pkg::*;

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int RST_LEN = (RESET_LENGTH > DEPTH) ? DEPTH : RESET_LENGTH;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_WR   = 7'b0001000,
        S_DRD  = 7'b0010000,
        S_DWT  = 7'b0100000,
        S_DOUT = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic signed [DATA_W-1:0]  set_reg, set_next;
    logic [DEPTH-1:0]          vld_reg, vld_next;
    logic                      vrd_reg;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [ADDR_W-1:0]         dcnt_reg, dcnt_next;
    logic                      ov_reg, ov_next;
    logic [DATA_W-1:0]         oval_reg, oval_next;
    logic [INDEX_W-1:0]        oidx_reg, oidx_next;
    logic                      olast_reg, olast_next;

    logic                      in_fire;
    logic                      cfg_fire;
    logic [LEN_CFG_W-1:0]      len_raw;
    logic                      div_start;
    logic                      div_done;
    logic [ADDR_W-1:0]         div_res;
    logic                      ram_we;
    logic [DATA_W-1:0]         ram_wdata;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;
    logic [DATA_W-1:0]         cur_val;
    logic                      dump_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign len_raw   = cfg_data[LEN_CFG_W-1:0];
    assign div_start = in_fire && (command == CMD_MARK);
    assign cur_val   = vrd_reg ? ram_rdata : '0;
    assign dump_last = (LEN_W'(LEN_W'(dcnt_reg) + LEN_W'(1)) == len_reg);

    wisct_div #(
        .LEN_W (LEN_W),
        .OUT_W (ADDR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (position),
        .divisor  (len_reg),
        .done     (div_done),
        .result   (div_res)
    );

    wisct_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = (state_reg == S_WR);
        ram_wdata = (set_reg != '0) ? set_reg : cur_val + DATA_W'(1);
        ram_re    = (state_reg == S_RD) || (state_reg == S_DRD);
        ram_raddr = (state_reg == S_RD) ? idx_reg : dcnt_reg;
    end

    always_comb
    begin
        len_next = len_reg;
        set_next = set_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_LIST_LENGTH:
                begin
                    if (len_raw == '0)
                    begin
                        len_next = LEN_W'(1);
                    end
                    else if (32'(len_raw) > 32'(DEPTH))
                    begin
                        len_next = LEN_W'(DEPTH);
                    end
                    else
                    begin
                        len_next = LEN_W'(len_raw);
                    end
                end
                REG_SET_VALUE:
                begin
                    set_next = cfg_data;
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        vld_next   = vld_reg;
        idx_next   = idx_reg;
        dcnt_next  = dcnt_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (command)
                        CMD_MARK:
                        begin
                            state_next = S_DIV;
                        end
                        CMD_CLEAR:
                        begin
                            vld_next = '0;
                        end
                        CMD_DUMP:
                        begin
                            dcnt_next  = '0;
                            state_next = S_DRD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = div_res;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                vld_next[idx_reg] = 1'b1;
                state_next        = S_IDLE;
            end
            S_DRD:
            begin
                state_next = S_DWT;
            end
            S_DWT:
            begin
                ov_next    = 1'b1;
                oval_next  = cur_val;
                oidx_next  = INDEX_W'(dcnt_reg);
                olast_next = dump_last;
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dcnt_next  = dcnt_reg + ADDR_W'(1);
                        state_next = S_DRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= LEN_W'(RST_LEN);
            set_reg   <= '0;
            vld_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            set_reg   <= set_next;
            vld_reg   <= vld_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            vrd_reg <= vld_reg[ram_raddr];
        end
        idx_reg   <= idx_next;
        dcnt_reg  <= dcnt_next;
        oval_reg  <= oval_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = ov_reg;
    assign entry_value = oval_reg;
    assign entry_index = oidx_reg;
    assign last_entry  = olast_reg;

    a_no_accept_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while a result is pending");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg >= LEN_W'(1)) && (32'(len_reg) <= 32'(DEPTH)))
        else $error("list length outside 1..DEPTH");

    a_wrapped_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> (LEN_W'(idx_reg) < len_reg))
        else $error("wrapped index not below list length");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("modulo unit finished outside its wait state");

    a_dump_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_entry) |=> (state_reg == S_IDLE))
        else $error("dump did not return to idle after its last entry");

endmodule

`default_nettype wire
